FILE: rtl/core/skeleton_minutia_detector_defines.svh
// assertion helpers for the minutia detector
`ifndef SKELETON_MINUTIA_DETECTOR_DEFINES_SVH
`define SKELETON_MINUTIA_DETECTOR_DEFINES_SVH

// condition implies property in the same cycle
`define SMD_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// condition implies property in the next cycle
`define SMD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/core/smd_pkg.sv
package smd_pkg;

  // coordinate width, wide enough that a step to -1 wraps beyond any frame
  localparam int COORD_W = 11;
  // cordic datapath widths
  localparam int CORDIC_W = 38;
  localparam int ZW = 34;
  localparam int CORDIC_STEPS = 26;
  localparam int ITER_W = 5;
  localparam int SUM_W = 36;

  localparam logic signed [CORDIC_W-1:0] INV_GAIN = 38'sd652032874;
  localparam logic signed [ZW-1:0] Z_HALF = 34'sh0_8000_0000;
  localparam logic signed [ZW-1:0] Z_QUARTER = 34'sh0_4000_0000;

  // request opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EXAMINE = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_END = 2'd1;
  localparam logic [1:0] KIND_BIF = 2'd2;

  typedef enum logic [1:0] {
    CFG_STEP_LIMIT   = 2'd0,
    CFG_MIN_BRANCH   = 2'd1,
    CFG_FRAME_WIDTH  = 2'd2,
    CFG_FRAME_HEIGHT = 2'd3
  } cfg_index_t;

  typedef enum logic [18:0] {
    S_IDLE   = 19'h00001,
    S_CREAD  = 19'h00002,
    S_CWAIT  = 19'h00004,
    S_NREAD  = 19'h00008,
    S_NWAIT  = 19'h00010,
    S_CLASS  = 19'h00020,
    S_WSEL   = 19'h00040,
    S_WCAND  = 19'h00080,
    S_WWAIT  = 19'h00100,
    S_WVEC   = 19'h00200,
    S_VRUN   = 19'h00400,
    S_WEND   = 19'h00800,
    S_DECIDE = 19'h01000,
    S_ULOAD  = 19'h02000,
    S_RRUN   = 19'h04000,
    S_UEND   = 19'h08000,
    S_SLOAD  = 19'h10000,
    S_SEND   = 19'h20000,
    S_OUT    = 19'h40000
  } state_t;

  // ring offsets in coordinate-width two's complement
  function automatic logic [COORD_W-1:0] ring_dx(input logic [2:0] idx);
    logic [COORD_W-1:0] d;
    case (idx)
      3'd0, 3'd1, 3'd7: d = COORD_W'(1);
      3'd3, 3'd4, 3'd5: d = '1;
      default:          d = '0;
    endcase
    return d;
  endfunction

  function automatic logic [COORD_W-1:0] ring_dy(input logic [2:0] idx);
    logic [COORD_W-1:0] d;
    case (idx)
      3'd5, 3'd6, 3'd7: d = COORD_W'(1);
      3'd1, 3'd2, 3'd3: d = '1;
      default:          d = '0;
    endcase
    return d;
  endfunction

  // atan(2^-i) as a fraction of a turn, 32 bits
  function automatic logic [31:0] atan_turn(input logic [ITER_W-1:0] i);
    logic [31:0] t;
    case (i)
      5'd0:  t = 32'h20000000;
      5'd1:  t = 32'h12E4051E;
      5'd2:  t = 32'h09FB385B;
      5'd3:  t = 32'h051111D4;
      5'd4:  t = 32'h028B0D43;
      5'd5:  t = 32'h0145D7E1;
      5'd6:  t = 32'h00A2F61E;
      5'd7:  t = 32'h00517C55;
      5'd8:  t = 32'h0028BE53;
      5'd9:  t = 32'h00145F2F;
      5'd10: t = 32'h000A2F98;
      5'd11: t = 32'h000517CC;
      5'd12: t = 32'h00028BE6;
      5'd13: t = 32'h000145F3;
      5'd14: t = 32'h0000A2FA;
      5'd15: t = 32'h0000517D;
      5'd16: t = 32'h000028BE;
      5'd17: t = 32'h0000145F;
      5'd18: t = 32'h00000A30;
      5'd19: t = 32'h00000518;
      5'd20: t = 32'h0000028C;
      5'd21: t = 32'h00000146;
      5'd22: t = 32'h000000A3;
      5'd23: t = 32'h00000051;
      5'd24: t = 32'h00000029;
      5'd25: t = 32'h00000014;
      default: t = 32'h0;
    endcase
    return t;
  endfunction

endpackage

FILE: rtl/core/smd_ram.sv
module smd_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 262144
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/skeleton_minutia_detector.sv
// write request: accepted while idle, no result; the next request may follow at once.
// examine request: ends early when rejected at the border, off the skeleton or mask, or when
// the crossing number ends it (center and 8 neighbour reads through the registered pixel
// port); per branch a walk of up to step_limit steps plus a pass of the shared cordic; a
// bifurcation adds 2*nb cordic passes. One request at a time; a held result stalls.
// reset restores register defaults and clears control; the pixel memory is not cleared.
module skeleton_minutia_detector #(
  parameter int MAX_WIDTH = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  op,
  input  logic [8:0]            col,
  input  logic [8:0]            row,
  input  logic                  skeleton_bit,
  input  logic                  inside_bit,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            kind,
  output logic [ANGLE_BITS-1:0] angle,
  output logic [2:0]            crossing_count,
  output logic [3:0]            branch_count,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [9:0]            cfg_data
);

  `include "skeleton_minutia_detector_defines.svh"

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = $clog2(DEPTH);
  localparam int XW = smd_pkg::COORD_W;
  localparam int CW = smd_pkg::CORDIC_W;
  localparam int ZW = smd_pkg::ZW;
  localparam int SW = smd_pkg::SUM_W;
  localparam int IW = smd_pkg::ITER_W;

  smd_pkg::state_t state;

  logic [5:0] step_limit, spur_min;
  logic [9:0] frame_width, frame_height;
  logic [12:0] fw_ext, fh_ext, eff_w13, eff_h13;
  logic [XW-1:0] eff_w, eff_h;

  logic in_acc, wr_en, out_free;
  logic [XW-1:0] in_x, in_y;
  logic in_border_ok;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [1:0] rd_data;

  // examine context
  logic [XW-1:0] ctr_x, ctr_y, px, py, wx, wy;
  logic [2:0] ri, bi;
  logic [7:0] nbr;
  logic [5:0] steps, len0;
  logic [3:0] slot;
  logic [2:0] slot3;
  logic stem, have, rot_neg;
  logic [31:0] best;
  logic [1:0] res_kind;
  logic [31:0] res_theta;
  logic [2:0] res_cn;
  logic [3:0] res_nb;
  logic [31:0] ang [8];
  logic signed [31:0] uc [8];
  logic signed [31:0] us [8];
  logic signed [SW-1:0] sumx, sumy;

  // neighbour candidate
  logic [XW-1:0] base_x, base_y, cand_x, cand_y, rd_x, rd_y;
  logic cand_in, cand_excl;

  // classification
  logic [7:0] trans;
  logic [2:0] cn;
  logic [3:0] nb_cnt;

  // shared cordic unit
  logic signed [CW-1:0] cor_x, cor_y;
  logic signed [ZW-1:0] cor_z;
  logic [IW-1:0] iter;
  logic signed [CW-1:0] xsh, ysh, x_step, y_step;
  logic signed [ZW-1:0] atan_z, z_step;
  logic cor_sub, vec_done, rot_done;
  logic signed [11:0] dxv, dyv;
  logic signed [CW-1:0] vin_x, vin_y;
  logic signed [ZW-1:0] rot_za;
  logic signed [CW-1:0] cval, sval;
  logic [31:0] diff, dabs;
  logic [32:0] round_sum;

  // effective frame size, clipped to the memory
  assign fw_ext = 13'(frame_width);
  assign fh_ext = 13'(frame_height);
  assign eff_w13 = (fw_ext > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : fw_ext;
  assign eff_h13 = (fh_ext > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : fh_ext;
  assign eff_w = eff_w13[XW-1:0];
  assign eff_h = eff_h13[XW-1:0];

  // input side
  assign in_stall = (state != smd_pkg::S_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_x = XW'(col);
  assign in_y = XW'(row);
  assign in_border_ok = (col != 9'd0) && (row != 9'd0) &&
                        (in_x + XW'(1) < eff_w) && (in_y + XW'(1) < eff_h);
  assign wr_en = in_acc && (op == smd_pkg::OP_WRITE) &&
                 (13'(col) < 13'(MAX_WIDTH)) && (13'(row) < 13'(MAX_HEIGHT));
  assign wr_addr = AW'(32'(row) * 32'(MAX_WIDTH) + 32'(col));

  // candidate neighbour of the center or of the walk head
  always_comb begin
    if (state == smd_pkg::S_WCAND || state == smd_pkg::S_WWAIT) begin
      base_x = wx;
      base_y = wy;
    end else begin
      base_x = ctr_x;
      base_y = ctr_y;
    end
    cand_x = base_x + smd_pkg::ring_dx(ri);
    cand_y = base_y + smd_pkg::ring_dy(ri);
    cand_in = (cand_x < eff_w) && (cand_y < eff_h);
    cand_excl = ((cand_x == px) && (cand_y == py)) ||
                ((cand_x == ctr_x) && (cand_y == ctr_y));
    rd_x = (state == smd_pkg::S_CREAD) ? ctr_x : cand_x;
    rd_y = (state == smd_pkg::S_CREAD) ? ctr_y : cand_y;
  end

  assign rd_addr = AW'(32'(rd_y) * 32'(MAX_WIDTH) + 32'(rd_x));

  smd_ram #(
    .WIDTH(2),
    .DEPTH(DEPTH)
  ) u_pixels (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data({skeleton_bit, inside_bit}),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // crossing number and neighbour count
  assign trans = nbr ^ {nbr[0], nbr[7:1]};
  assign cn = 3'(4'($countones(trans)) >> 1);
  assign nb_cnt = 4'($countones(nbr));
  assign slot3 = slot[2:0];

  // one cordic micro-rotation per cycle
  always_comb begin
    xsh = cor_x >>> iter;
    ysh = cor_y >>> iter;
    atan_z = $signed({{(ZW-32){1'b0}}, smd_pkg::atan_turn(iter)});
    cor_sub = (state == smd_pkg::S_RRUN) ? !cor_z[ZW-1] : cor_y[CW-1];
    x_step = cor_sub ? cor_x - ysh : cor_x + ysh;
    y_step = cor_sub ? cor_y + xsh : cor_y - xsh;
    z_step = cor_sub ? cor_z - atan_z : cor_z + atan_z;
    vec_done = (iter == IW'(smd_pkg::CORDIC_STEPS)) || (cor_y == '0);
    rot_done = (iter == IW'(smd_pkg::CORDIC_STEPS));
  end

  // vectoring inputs: walk vector or sum of the other unit vectors
  always_comb begin
    dxv = $signed({1'b0, wx}) - $signed({1'b0, ctr_x});
    dyv = $signed({1'b0, wy}) - $signed({1'b0, ctr_y});
    if (state == smd_pkg::S_SLOAD) begin
      vin_x = CW'(sumx - SW'(uc[slot3]));
      vin_y = CW'(sumy - SW'(us[slot3]));
    end else begin
      vin_x = CW'(dxv) <<< 20;
      vin_y = CW'(dyv) <<< 20;
    end
    rot_za = ZW'($signed(ang[slot3]));
    cval = rot_neg ? -cor_x : cor_x;
    sval = rot_neg ? -cor_y : cor_y;
    diff = ang[slot3] - cor_z[31:0];
    dabs = (diff > 32'h8000_0000) ? (32'h0 - diff) : diff;
    round_sum = {1'b0, res_theta} + (33'd1 << (31 - ANGLE_BITS));
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_limit <= 6'd12;
      spur_min <= 6'd5;
      frame_width <= 10'd512;
      frame_height <= 10'd512;
    end else if (cfg_write) begin
      case (smd_pkg::cfg_index_t'(cfg_index))
        smd_pkg::CFG_STEP_LIMIT:   step_limit <= cfg_data[5:0];
        smd_pkg::CFG_MIN_BRANCH:   spur_min <= cfg_data[5:0];
        smd_pkg::CFG_FRAME_WIDTH:  frame_width <= cfg_data;
        smd_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == smd_pkg::S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == smd_pkg::S_OUT && out_free) begin
      kind <= res_kind;
      angle <= (res_kind == smd_pkg::KIND_NONE) ? '0 : round_sum[31 -: ANGLE_BITS];
      crossing_count <= res_cn;
      branch_count <= res_nb;
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smd_pkg::S_IDLE;
    end else begin
      case (state)
        smd_pkg::S_IDLE: begin
          if (in_acc && op == smd_pkg::OP_EXAMINE) begin
            state <= in_border_ok ? smd_pkg::S_CREAD : smd_pkg::S_OUT;
          end
        end
        smd_pkg::S_CREAD: state <= smd_pkg::S_CWAIT;
        smd_pkg::S_CWAIT: state <= (rd_data == 2'b11) ? smd_pkg::S_NREAD : smd_pkg::S_OUT;
        smd_pkg::S_NREAD: state <= smd_pkg::S_NWAIT;
        smd_pkg::S_NWAIT: state <= (ri == 3'd7) ? smd_pkg::S_CLASS : smd_pkg::S_NREAD;
        smd_pkg::S_CLASS: begin
          state <= (cn == 3'd1 || cn == 3'd3) ? smd_pkg::S_WSEL : smd_pkg::S_OUT;
        end
        smd_pkg::S_WSEL: begin
          if (nbr[bi]) begin
            state <= (6'd1 < step_limit) ? smd_pkg::S_WCAND : smd_pkg::S_WVEC;
          end else if (bi == 3'd7) begin
            state <= smd_pkg::S_DECIDE;
          end
        end
        smd_pkg::S_WCAND: begin
          if (cand_in && !cand_excl) begin
            state <= smd_pkg::S_WWAIT;
          end else if (ri == 3'd7) begin
            state <= smd_pkg::S_WVEC;
          end
        end
        smd_pkg::S_WWAIT: begin
          if (rd_data[1]) begin
            state <= (7'(steps) + 7'd1 < 7'(step_limit)) ? smd_pkg::S_WCAND
                                                         : smd_pkg::S_WVEC;
          end else begin
            state <= (ri == 3'd7) ? smd_pkg::S_WVEC : smd_pkg::S_WCAND;
          end
        end
        smd_pkg::S_WVEC: state <= smd_pkg::S_VRUN;
        smd_pkg::S_VRUN: begin
          if (vec_done) begin
            state <= stem ? smd_pkg::S_SEND : smd_pkg::S_WEND;
          end
        end
        smd_pkg::S_WEND: begin
          state <= (res_cn == 3'd1 || bi == 3'd7) ? smd_pkg::S_DECIDE : smd_pkg::S_WSEL;
        end
        smd_pkg::S_DECIDE: begin
          state <= (res_cn == 3'd3 && res_nb >= 4'd3) ? smd_pkg::S_ULOAD : smd_pkg::S_OUT;
        end
        smd_pkg::S_ULOAD: state <= smd_pkg::S_RRUN;
        smd_pkg::S_RRUN: if (rot_done) state <= smd_pkg::S_UEND;
        smd_pkg::S_UEND: begin
          state <= (slot + 4'd1 == res_nb) ? smd_pkg::S_SLOAD : smd_pkg::S_ULOAD;
        end
        smd_pkg::S_SLOAD: state <= smd_pkg::S_VRUN;
        smd_pkg::S_SEND: begin
          state <= (slot + 4'd1 == res_nb) ? smd_pkg::S_OUT : smd_pkg::S_SLOAD;
        end
        smd_pkg::S_OUT: if (out_free) state <= smd_pkg::S_IDLE;
        default: state <= smd_pkg::S_IDLE;
      endcase
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    case (state)
      smd_pkg::S_IDLE: begin
        ctr_x <= in_x;
        ctr_y <= in_y;
        res_kind <= smd_pkg::KIND_NONE;
        res_theta <= '0;
        res_cn <= '0;
        res_nb <= '0;
        stem <= 1'b0;
        ri <= '0;
      end
      smd_pkg::S_NWAIT: begin
        nbr[ri] <= rd_data[1];
        ri <= ri + 3'd1;
      end
      smd_pkg::S_CLASS: begin
        res_cn <= cn;
        if (cn == 3'd1 || cn == 3'd3) begin
          res_nb <= nb_cnt;
        end
        bi <= '0;
        slot <= '0;
      end
      smd_pkg::S_WSEL: begin
        if (nbr[bi]) begin
          px <= ctr_x;
          py <= ctr_y;
          wx <= ctr_x + smd_pkg::ring_dx(bi);
          wy <= ctr_y + smd_pkg::ring_dy(bi);
          steps <= 6'd1;
          ri <= '0;
        end else begin
          bi <= bi + 3'd1;
        end
      end
      smd_pkg::S_WCAND: begin
        if (!(cand_in && !cand_excl)) begin
          ri <= ri + 3'd1;
        end
      end
      smd_pkg::S_WWAIT: begin
        if (rd_data[1]) begin
          px <= wx;
          py <= wy;
          wx <= cand_x;
          wy <= cand_y;
          steps <= steps + 6'd1;
          ri <= '0;
        end else begin
          ri <= ri + 3'd1;
        end
      end
      smd_pkg::S_WVEC, smd_pkg::S_SLOAD: begin
        iter <= '0;
        if (vin_x < 0) begin
          cor_x <= -vin_x;
          cor_y <= -vin_y;
          cor_z <= smd_pkg::Z_HALF;
        end else begin
          cor_x <= vin_x;
          cor_y <= vin_y;
          cor_z <= '0;
        end
      end
      smd_pkg::S_VRUN, smd_pkg::S_RRUN: begin
        if (!(state == smd_pkg::S_VRUN ? vec_done : rot_done)) begin
          cor_x <= x_step;
          cor_y <= y_step;
          cor_z <= z_step;
          iter <= iter + IW'(1);
        end
      end
      smd_pkg::S_WEND: begin
        ang[slot3] <= cor_z[31:0];
        if (slot == 4'd0) begin
          len0 <= steps;
        end
        slot <= slot + 4'd1;
        bi <= bi + 3'd1;
      end
      smd_pkg::S_DECIDE: begin
        slot <= '0;
        sumx <= '0;
        sumy <= '0;
        have <= 1'b0;
        stem <= 1'b1;
        if (res_cn == 3'd1 && res_nb != 4'd0 && len0 >= spur_min) begin
          res_kind <= smd_pkg::KIND_END;
          res_theta <= ang[0];
        end
      end
      smd_pkg::S_ULOAD: begin
        iter <= '0;
        cor_x <= smd_pkg::INV_GAIN;
        cor_y <= '0;
        if (rot_za > smd_pkg::Z_QUARTER) begin
          cor_z <= rot_za - smd_pkg::Z_HALF;
          rot_neg <= 1'b1;
        end else if (rot_za < -smd_pkg::Z_QUARTER) begin
          cor_z <= rot_za + smd_pkg::Z_HALF;
          rot_neg <= 1'b1;
        end else begin
          cor_z <= rot_za;
          rot_neg <= 1'b0;
        end
      end
      smd_pkg::S_UEND: begin
        uc[slot3] <= cval[31:0];
        us[slot3] <= sval[31:0];
        sumx <= sumx + SW'(cval);
        sumy <= sumy + SW'(sval);
        slot <= (slot + 4'd1 == res_nb) ? 4'd0 : slot + 4'd1;
      end
      smd_pkg::S_SEND: begin
        if (!have || dabs > best) begin
          have <= 1'b1;
          best <= dabs;
          res_theta <= ang[slot3];
        end
        slot <= slot + 4'd1;
        if (slot + 4'd1 == res_nb) begin
          res_kind <= smd_pkg::KIND_BIF;
        end
      end
      default: ;
    endcase
  end

  // checks
  `SMD_ASSERT_NOW(a_end_shape, out_valid && kind == smd_pkg::KIND_END, crossing_count == 3'd1 && branch_count != 4'd0, "ridge ending without crossing number one")
  `SMD_ASSERT_NOW(a_bif_shape, out_valid && kind == smd_pkg::KIND_BIF, crossing_count == 3'd3 && branch_count >= 4'd3, "bifurcation with too few branches")
  `SMD_ASSERT_NOW(a_none_angle, out_valid && kind == smd_pkg::KIND_NONE, angle == '0, "angle given without a minutia")
  `SMD_ASSERT_NOW(a_iter_bound, state == smd_pkg::S_VRUN || state == smd_pkg::S_RRUN, iter <= IW'(smd_pkg::CORDIC_STEPS), "cordic ran past its last step")
  `SMD_ASSERT_NEXT(a_result_load, state == smd_pkg::S_OUT && out_free, out_valid && state == smd_pkg::S_IDLE, "finished result not presented")

endmodule
